[hw/rtl/pls_pkg.sv]
`default_nettype none

package pls_pkg;

    localparam int DEPTH      = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ACT_W      = 3;
    localparam int POS_W      = 5;
    localparam int VAL_W      = 32;
    localparam int STS_W      = 2;
    localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic [ACT_W-1:0] ACT_ADD_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_REAR  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REM_FRONT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REM_REAR  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_INSERT_AT = 3'd4;
    localparam logic [ACT_W-1:0] ACT_REMOVE_AT = 3'd5;

    localparam logic [STS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STS_W-1:0] ST_FULL      = 2'd3;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_REM  = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } pls_req_t;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [VAL_W-1:0] removed_value;
        logic [CNT_W-1:0] count_now;
        logic             is_empty;
    } pls_rsp_t;

    typedef struct packed {
        logic [1:0]            op;
        logic [IDX_W-1:0]      idx;
        logic [ELEM_WIDTH-1:0] data;
    } pls_cell_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/pls_cell.sv]
`default_nettype none

module pls_cell
    import pls_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic [IDX_W-1:0]      index,
    input  wire pls_cell_cmd_t         cmd,
    input  wire logic [ELEM_WIDTH-1:0] left_data,
    input  wire logic [ELEM_WIDTH-1:0] right_data,
    output logic [ELEM_WIDTH-1:0]      data,
    output logic [ELEM_WIDTH-1:0]      tap
);

    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            OP_INS:
            begin
                if (index == cmd.idx)
                begin
                    data_next = cmd.data;
                end
                else if (index > cmd.idx)
                begin
                    data_next = left_data;
                end
            end
            OP_REM:
            begin
                if (index >= cmd.idx)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = ((cmd.op == OP_REM) && (index == cmd.idx)) ? data_reg : '0;

endmodule

`default_nettype wire

[hw/rtl/pls_ctrl.sv]
`default_nettype none

module pls_ctrl
    import pls_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire pls_req_t              req,
    input  wire logic [ELEM_WIDTH-1:0] taken,
    output pls_cell_cmd_t              cmd,
    output logic                       done,
    output pls_rsp_t                   rsp
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    pls_rsp_t         rsp_reg;
    pls_rsp_t         rsp_next;
    logic [STS_W-1:0] status;
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] cnt_w;
    logic             full;
    logic             empty;

    assign pos_w = CMP_W'(req.position);
    assign cnt_w = CMP_W'(count_reg);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        status = ST_OK;
        op     = OP_HOLD;
        idx    = '0;
        case (req.action)
            ACT_ADD_FRONT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    op = OP_INS;
                end
            end
            ACT_ADD_REAR:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    op  = OP_INS;
                    idx = count_reg[IDX_W-1:0];
                end
            end
            ACT_REM_FRONT:
            begin
                if (empty)
                begin
                    status = ST_UNDERFLOW;
                end
                else
                begin
                    op = OP_REM;
                end
            end
            ACT_REM_REAR:
            begin
                if (empty)
                begin
                    status = ST_UNDERFLOW;
                end
                else
                begin
                    op  = OP_REM;
                    idx = IDX_W'(count_reg - CNT_W'(1));
                end
            end
            ACT_INSERT_AT:
            begin
                if ((pos_w == '0) || (pos_w > cnt_w + CMP_W'(1)))
                begin
                    status = ST_RANGE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    op  = OP_INS;
                    idx = IDX_W'(pos_w - CMP_W'(1));
                end
            end
            ACT_REMOVE_AT:
            begin
                if ((pos_w == '0) || (pos_w > cnt_w))
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    op  = OP_REM;
                    idx = IDX_W'(pos_w - CMP_W'(1));
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        cmd.op   = fire ? op : OP_HOLD;
        cmd.idx  = idx;
        cmd.data = ELEM_WIDTH'(req.value);

        count_next = count_reg;
        if (fire && (op == OP_INS))
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (fire && (op == OP_REM))
        begin
            count_next = count_reg - CNT_W'(1);
        end

        rsp_next.status        = status;
        rsp_next.removed_value = VAL_W'(taken);
        rsp_next.count_now     = count_next;
        rsp_next.is_empty      = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

[hw/rtl/positional_list_store_core.sv]
`default_nettype none

// the done strobe and the result are registered at the edge that accepts the transaction
// throughput: one transaction per cycle, busy stays low
// storage is a row of cells; the cells at and past the addressed one shift in the same cycle
// reset clears the element count and the done strobe; cell contents are not cleared
// the receiver cannot stall: each result is shown for exactly one cycle

module positional_list_store_core
    import pls_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire pls_req_t req,
    output logic          done,
    output pls_rsp_t      rsp
);

    pls_cell_cmd_t         cmd;
    logic                  fire;
    logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
    logic [ELEM_WIDTH-1:0] cell_tap  [DEPTH];
    logic [ELEM_WIDTH-1:0] taken;

    assign busy = 1'b0;
    assign fire = start && !busy;

    pls_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (req),
        .taken (taken),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ELEM_WIDTH-1:0] left_data;
        logic [ELEM_WIDTH-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        pls_cell u_cell (
            .clk        (clk),
            .index      (IDX_W'(i)),
            .cmd        (cmd),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    // only the addressed cell drives a nonzero tap on a remove
    always_comb
    begin
        taken = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            taken = taken | cell_tap[k];
        end
    end

endmodule

`default_nettype wire

[tb/positional_list_store_core_test.sv]
module positional_list_store_core_test
    import pls_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_TXNS = 1600;
    localparam int QUIET_TAIL = 150;
    localparam int STALL_LIMIT = 1000;

    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        pls_req_t req;
        bit       may_idle;
        bit       drain_first;
    } list_txn_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    pls_req_t req;
    logic     done;
    pls_rsp_t rsp;

    list_txn_t pending_items[$];
    pls_rsp_t  expected_rsps[$];

    logic [ELEM_WIDTH-1:0] list_elems[DEPTH];
    int list_count;

    bit item_taken;
    int idle_left;
    int stall_cycles;
    int mismatches;
    int results_checked;
    int peak_count;
    int status_hits[4];
    int action_hits[8];

    positional_list_store_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [STS_W-1:0] place_elem(int slot, logic [ELEM_WIDTH-1:0] v);
        if (list_count >= DEPTH)
            return ST_FULL;
        if (slot > list_count)
            return ST_RANGE;
        for (int i = list_count; i > slot; i--)
            list_elems[i] = list_elems[i-1];
        list_elems[slot] = v;
        list_count++;
        return ST_OK;
    endfunction

    function automatic logic [ELEM_WIDTH-1:0] pull_elem(int slot);
        logic [ELEM_WIDTH-1:0] v;
        v = list_elems[slot];
        for (int i = slot; i < list_count - 1; i++)
            list_elems[i] = list_elems[i+1];
        list_count--;
        return v;
    endfunction

    // applies one transaction to the shadow list and returns what the block must report
    function automatic pls_rsp_t apply_list_op(pls_req_t r);
        pls_rsp_t o;
        logic [STS_W-1:0] sts;
        logic [VAL_W-1:0] taken;
        int pos;
        sts = ST_OK;
        taken = '0;
        pos = int'(r.position);
        case (r.action)
            ACT_ADD_FRONT: sts = place_elem(0, r.value);
            ACT_ADD_REAR:  sts = place_elem(list_count, r.value);
            ACT_REM_FRONT:
            begin
                if (list_count == 0)
                    sts = ST_UNDERFLOW;
                else
                    taken = pull_elem(0);
            end
            ACT_REM_REAR:
            begin
                if (list_count == 0)
                    sts = ST_UNDERFLOW;
                else
                    taken = pull_elem(list_count - 1);
            end
            ACT_INSERT_AT:
            begin
                if (pos < 1 || pos > list_count + 1)
                    sts = ST_RANGE;
                else
                    sts = place_elem(pos - 1, r.value);
            end
            ACT_REMOVE_AT:
            begin
                if (pos < 1 || pos > list_count)
                    sts = ST_RANGE;
                else
                    taken = pull_elem(pos - 1);
            end
            default: ;
        endcase
        o.status = sts;
        o.removed_value = taken;
        o.count_now = list_count[CNT_W-1:0];
        o.is_empty = (list_count == 0);
        return o;
    endfunction

    // queues a transaction and runs it through the shadow list so later positions can be aimed
    task automatic add_txn(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                           logic [VAL_W-1:0] val, bit may_idle, bit drain_first);
        list_txn_t t;
        pls_rsp_t unused;
        t.req.action = act;
        t.req.position = pos;
        t.req.value = val;
        t.may_idle = may_idle;
        t.drain_first = drain_first;
        pending_items.push_back(t);
        unused = apply_list_op(t.req);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n || (start && !item_taken))
        begin
        end
        else if (idle_left > 0)
        begin
            start <= 1'b0;
            idle_left <= idle_left - 1;
        end
        else if (pending_items.size() == 0 ||
                 (pending_items[0].drain_first && expected_rsps.size() != 0))
        begin
            start <= 1'b0;
        end
        else if (pending_items[0].may_idle && $urandom_range(0, 9) == 0)
        begin
            start <= 1'b0;
            idle_left <= $urandom_range(0, 5);
        end
        else
        begin
            start <= 1'b1;
            req <= pending_items[0].req;
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        pls_rsp_t want;
        pls_rsp_t next_rsp;
        list_txn_t gone;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: result with no transaction outstanding, expected none, actual %p",
                             $time, rsp);
                    mismatches++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    flag_field("status", 32'(want.status), 32'(rsp.status));
                    flag_field("removed_value", want.removed_value, rsp.removed_value);
                    flag_field("count_now", 32'(want.count_now), 32'(rsp.count_now));
                    flag_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
                    results_checked++;
                end
            end
            item_taken = start && !busy;
            if (item_taken)
            begin
                next_rsp = apply_list_op(req);
                expected_rsps.push_back(next_rsp);
                gone = pending_items.pop_front();
                status_hits[next_rsp.status]++;
                action_hits[req.action]++;
                if (list_count > peak_count)
                    peak_count = list_count;
            end
            if (item_taken || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: watchdog, no transaction for %0d cycles", $time, stall_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int bias;
        bit quiet;
        bit idle_ok;
        bit grow;
        bit drain;
        int first_random;
        logic [31:0] rnd;
        logic [ACT_W-1:0] act;
        logic [POS_W-1:0] pos;

        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        item_taken = 1'b0;
        idle_left = 0;
        stall_cycles = 0;
        mismatches = 0;
        results_checked = 0;
        peak_count = 0;
        list_count = 0;
        bias = 2;
        quiet = 1'b0;

        // empty list corner cases
        add_txn(ACT_REM_FRONT, 5'd0, '0, 1'b1, 1'b0);
        add_txn(ACT_REM_REAR, 5'd31, '1, 1'b1, 1'b0);
        add_txn(ACT_REMOVE_AT, 5'd1, '0, 1'b1, 1'b0);
        add_txn(ACT_INSERT_AT, 5'd0, '1, 1'b1, 1'b0);
        add_txn(ACT_INSERT_AT, 5'd2, '1, 1'b1, 1'b0);
        add_txn(ACT_INSERT_AT, 5'd1, '1, 1'b1, 1'b0);
        add_txn(ACT_SPARE_LO, 5'd31, '1, 1'b1, 1'b0);
        add_txn(ACT_SPARE_HI, 5'd1, '0, 1'b1, 1'b0);
        add_txn(ACT_REMOVE_AT, 5'd2, '0, 1'b1, 1'b0);
        add_txn(ACT_REMOVE_AT, 5'd1, '0, 1'b1, 1'b0);
        // fill to capacity with every kind of add
        for (int i = 0; i < DEPTH; i++)
        begin
            rnd = i / 2 + 1;
            case (i % 3)
                0: add_txn(ACT_ADD_FRONT, 5'd0, (i == 0) ? '0 : pick_value(), 1'b1, 1'b0);
                1: add_txn(ACT_ADD_REAR, 5'd0, pick_value(), 1'b1, 1'b0);
                default: add_txn(ACT_INSERT_AT, rnd[POS_W-1:0], pick_value(), 1'b1, 1'b0);
            endcase
        end
        // full list corner cases
        add_txn(ACT_ADD_REAR, 5'd0, '1, 1'b1, 1'b0);
        add_txn(ACT_INSERT_AT, 5'd17, '0, 1'b1, 1'b0);
        add_txn(ACT_INSERT_AT, 5'd31, '1, 1'b1, 1'b0);
        add_txn(ACT_REMOVE_AT, 5'd17, '0, 1'b1, 1'b0);
        add_txn(ACT_REMOVE_AT, 5'd16, '0, 1'b1, 1'b0);

        first_random = pending_items.size();
        for (int n = first_random; n < TOTAL_TXNS; n++)
        begin
            // phases lean toward filling, draining, or neither
            if ((n - first_random) % 48 == 0)
            begin
                bias = $urandom_range(0, 2);
                quiet = ($urandom_range(0, 3) == 0);
            end
            idle_ok = !quiet && (n < TOTAL_TXNS - QUIET_TAIL);
            drain = (n == first_random) ||
                    ((n < TOTAL_TXNS - QUIET_TAIL) && ($urandom_range(0, 199) == 0));
            case (bias)
                0: grow = ($urandom_range(0, 9) < 7);
                1: grow = ($urandom_range(0, 9) < 3);
                default: grow = ($urandom_range(0, 1) == 0);
            endcase
            if ($urandom_range(0, 11) == 0)
            begin
                rnd = $urandom;
                act = rnd[ACT_W-1:0];
                pos = rnd[ACT_W+POS_W-1:ACT_W];
            end
            else if (grow)
            begin
                rnd = $urandom_range(1, list_count + 1);
                pos = rnd[POS_W-1:0];
                case ($urandom_range(0, 2))
                    0: act = ACT_ADD_FRONT;
                    1: act = ACT_ADD_REAR;
                    default: act = ACT_INSERT_AT;
                endcase
            end
            else
            begin
                rnd = $urandom_range(1, (list_count == 0) ? 1 : list_count);
                pos = rnd[POS_W-1:0];
                case ($urandom_range(0, 2))
                    0: act = ACT_REM_FRONT;
                    1: act = ACT_REM_REAR;
                    default: act = ACT_REMOVE_AT;
                endcase
            end
            add_txn(act, pos, pick_value(), idle_ok, drain);
        end

        // shadow list starts over for the real run
        list_count = 0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("covered %0d transactions (adds %0d/%0d/%0d, removes %0d/%0d/%0d, spare codes %0d)",
                 results_checked, action_hits[ACT_ADD_FRONT], action_hits[ACT_ADD_REAR],
                 action_hits[ACT_INSERT_AT], action_hits[ACT_REM_FRONT],
                 action_hits[ACT_REM_REAR], action_hits[ACT_REMOVE_AT],
                 action_hits[ACT_SPARE_LO] + action_hits[ACT_SPARE_HI]);
        $display("status ok %0d, underflow %0d, out of range %0d, full %0d; list peaked at %0d",
                 status_hits[ST_OK], status_hits[ST_UNDERFLOW], status_hits[ST_RANGE],
                 status_hits[ST_FULL], peak_count);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
